// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the SHA-256 block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define SHA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SHA_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Constants, types and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  LAST_BYTE  = 6'd63;
  localparam logic [5:0]  LAST_ROUND = 6'd63;
  localparam logic [2:0]  LAST_WORD  = 3'd7;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  // Index 0 is the first chaining word.
  localparam logic [7:0][31:0] HASH_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       init;   // chaining words back to IV
    logic       load;   // working vars from chaining words
    logic       round;  // one compression round
    logic       fold;   // feed-forward add
    logic       shift;  // byte into block line
    logic [5:0] rnd;    // round number
  } ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// File: src/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream; a finish word pads and returns the digest.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                                     | word
//  --------+-----+-------------------------------------------+---------------------
//  in      | in  | in_valid/in_ready, in_req_type, in_data_byte | byte or finish
//  out     | out | out_valid/out_ready, out_digest_word,     | one digest word
//          |     | out_word_index, out_last                  |
//
//  An append word shifts its byte into the block line; every 64th byte then runs the
//  compression, 64 rounds at one a cycle and then the feed-forward add.
//  A finish word runs padding one byte a cycle (64 - fill, plus 64 more when
//  56 or more bytes are held), one compression per padded block, then 8 out words.
//  in_ready is low from a block-closing byte or a finish until idle again.
//  Reset (rst_n, synchronous) restores the initial hash; the block line
//  needs none. out stalls simply hold the current word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);

  sha256_pkg::state_t state_r, state_nxt;
  sha256_pkg::ctl_t   ctl;

  logic [5:0]       fill_r, fill_nxt;       // bytes held in the block line
  logic [63:0]      msg_bits_r, msg_bits_nxt; // bits in completed blocks
  logic [63:0]      total_r, total_nxt;     // length field, shifted out MSB first
  logic             extra_r, extra_nxt;     // padding needs a further block
  logic             first_r, first_nxt;     // next pad byte is the 0x80 marker
  logic             final_r, final_nxt;     // current block is the last one
  logic             pad_r, pad_nxt;         // finish in progress
  logic [5:0]       rnd_r, rnd_nxt;
  logic [2:0]       oidx_r, oidx_nxt;
  logic [7:0]       byte_sel;
  logic [31:0]      w_cur;
  logic [7:0][31:0] hash;
  logic             round_done;             // final round this cycle
  logic             in_fold;
  logic             last_taken;             // word 7 leaves this cycle

  assign in_ready        = (state_r == sha256_pkg::ST_IDLE);
  assign out_valid       = (state_r == sha256_pkg::ST_OUT);
  assign out_digest_word = hash[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last        = (oidx_r == sha256_pkg::LAST_WORD);

  // Sequencer: feeds bytes, steps the round unit and walks the digest out.
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    msg_bits_nxt = msg_bits_r;
    total_nxt    = total_r;
    extra_nxt    = extra_r;
    first_nxt    = first_r;
    final_nxt    = final_r;
    pad_nxt      = pad_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    byte_sel     = in_data_byte;
    ctl          = '0;
    ctl.rnd      = rnd_r;

    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!in_req_type) begin
            ctl.shift = 1'b1;
            fill_nxt  = fill_r + 6'd1;
            if (fill_r == sha256_pkg::LAST_BYTE) begin
              ctl.load     = 1'b1;
              msg_bits_nxt = msg_bits_r + sha256_pkg::BLOCK_BITS;
              rnd_nxt      = '0;
              final_nxt    = 1'b0;
              state_nxt    = sha256_pkg::ST_ROUND;
            end
          end else begin
            total_nxt = msg_bits_r + {55'd0, fill_r, 3'd0};
            extra_nxt = (fill_r >= sha256_pkg::LEN_POS);
            first_nxt = 1'b1;
            pad_nxt   = 1'b1;
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end

      sha256_pkg::ST_PAD: begin
        ctl.shift = 1'b1;
        if (first_r) begin
          byte_sel = sha256_pkg::PAD_BYTE;
        end else if (fill_r >= sha256_pkg::LEN_POS && !extra_r) begin
          byte_sel  = total_r[63:56];
          total_nxt = {total_r[55:0], 8'd0};
        end else begin
          byte_sel = 8'd0;
        end
        first_nxt = 1'b0;
        fill_nxt  = fill_r + 6'd1;
        if (fill_r == sha256_pkg::LAST_BYTE) begin
          ctl.load  = 1'b1;
          rnd_nxt   = '0;
          final_nxt = !extra_r;
          extra_nxt = 1'b0;
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end

      sha256_pkg::ST_ROUND: begin
        ctl.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == sha256_pkg::LAST_ROUND) begin
          state_nxt = sha256_pkg::ST_FOLD;
        end
      end

      sha256_pkg::ST_FOLD: begin
        ctl.fold = 1'b1;
        if (final_r) begin
          oidx_nxt  = '0;
          state_nxt = sha256_pkg::ST_OUT;
        end else if (pad_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end

      sha256_pkg::ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == sha256_pkg::LAST_WORD) begin
            ctl.init     = 1'b1;
            msg_bits_nxt = '0;
            fill_nxt     = '0;
            pad_nxt      = 1'b0;
            final_nxt    = 1'b0;
            state_nxt    = sha256_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha256_pkg::ST_IDLE;
      fill_r     <= '0;
      msg_bits_r <= '0;
      extra_r    <= 1'b0;
      first_r    <= 1'b0;
      final_r    <= 1'b0;
      pad_r      <= 1'b0;
      rnd_r      <= '0;
      oidx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      msg_bits_r <= msg_bits_nxt;
      extra_r    <= extra_nxt;
      first_r    <= first_nxt;
      final_r    <= final_nxt;
      pad_r      <= pad_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
    end
    total_r <= total_nxt;
  end

  sha256_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .byte_in (byte_sel),
    .w_cur   (w_cur)
  );

  sha256_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .w_cur  (w_cur),
    .hash_o (hash)
  );

  // Checks
  assign round_done = (state_r == sha256_pkg::ST_ROUND) && (rnd_r == sha256_pkg::LAST_ROUND);
  assign in_fold    = (state_r == sha256_pkg::ST_FOLD);
  assign last_taken = out_valid && out_ready && out_last;

  `SHA_ASSERT_RST(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "in and out both open")
  `SHA_ASSERT_RST(a_round_end, clk, rst_n, round_done |=> in_fold, "round count overrun")
  `SHA_ASSERT_RST(a_out_aligned, clk, rst_n, out_valid |-> (fill_r == '0), "partial block held")
  `SHA_ASSERT_RST(a_last_idle, clk, rst_n, last_taken |=> in_ready, "not idle after last word")

endmodule

// File: src/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// Block line and message schedule: bytes shift in, rounds slide the window.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic               clk,
  input  sha256_pkg::ctl_t   ctl,
  input  logic [7:0]         byte_in,
  output logic [31:0]        w_cur
);

  // Word k of the window sits at line_r[511-32k -: 32]; word 0 is the oldest.
  logic [511:0] line_r;
  logic [511:0] line_nxt;
  logic [31:0]  w_new;

  assign w_cur = line_r[511:480];

  assign w_new = sha256_pkg::small_sig1(line_r[63:32]) + line_r[223:192]
               + sha256_pkg::small_sig0(line_r[479:448]) + line_r[511:480];

  always_comb begin
    line_nxt = line_r;
    if (ctl.shift) begin
      line_nxt = {line_r[503:0], byte_in};
    end else if (ctl.round) begin
      line_nxt = {line_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

endmodule

// File: src/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Shared round unit: working variables, chaining words, feed-forward.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::ctl_t     ctl,
  input  logic [31:0]          w_cur,
  output logic [7:0][31:0]     hash_o
);

  logic [7:0][31:0] h_r, h_nxt;
  logic [7:0][31:0] v_r, v_nxt;
  logic [31:0]      t1, t2, ch, mj;

  assign hash_o = h_r;

  always_comb begin
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + sha256_pkg::big_sig1(v_r[4]) + ch
       + sha256_pkg::round_k(ctl.rnd) + w_cur;
    t2 = sha256_pkg::big_sig0(v_r[0]) + mj;

    v_nxt = v_r;
    h_nxt = h_r;
    if (ctl.load) begin
      v_nxt = h_r;
    end else if (ctl.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    if (ctl.init) begin
      h_nxt = sha256_pkg::HASH_INIT;
    end else if (ctl.fold) begin
      for (int k = 0; k < 8; k++) begin
        h_nxt[k] = h_r[k] + v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= sha256_pkg::HASH_INIT;
    end else begin
      h_r <= h_nxt;
    end
    v_r <= v_nxt;
  end

endmodule
